@@ rtl/core/qap_pkg.sv @@
// Shared types, constants and tables for the quadrature accelerated position unit.
// Depends on nothing; every other file in rtl/core takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package qap_pkg;

    // Field and storage widths
    localparam int POSITION_WIDTH = 32;
    localparam int TIME_WIDTH     = 48;
    localparam int BASE_WIDTH     = 16;
    localparam int ACCEL_WIDTH    = 20;
    localparam int STEP_WIDTH     = 20;
    localparam int PROD_WIDTH     = BASE_WIDTH + ACCEL_WIDTH;
    localparam int ACCEL_FRAC     = 16;
    localparam int LEVEL_WIDTH    = 4;
    localparam int LEVEL_COUNT    = 9;
    localparam int ACC_WIDTH      = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_POSITION = 2'd0,
        CFG_MAX_POSITION = 2'd1,
        CFG_BASE_STEP    = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic signed [POSITION_WIDTH-1:0] MIN_POSITION_RESET = '0;
    localparam logic signed [POSITION_WIDTH-1:0] MAX_POSITION_RESET = POSITION_WIDTH'(100);
    localparam logic [BASE_WIDTH-1:0]            BASE_STEP_RESET    = BASE_WIDTH'(1);

    // Input word: one pin sample
    typedef struct packed {
        logic                  pin_a;
        logic                  pin_b;
        logic [TIME_WIDTH-1:0] sample_us;
    } in_word_t;

    // Output word: one detent result
    typedef struct packed {
        logic                             direction_up;
        logic signed [POSITION_WIDTH-1:0] raw_count;
        logic signed [POSITION_WIDTH-1:0] mapped_position;
        logic                             position_changed;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_sample;
        logic decode;
        logic gap;
        logic rate;
        logic mul;
        logic commit;
    } qap_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic detent;
        logic out_free;
    } qap_status_t;

    // Q16 acceleration factors: round(1.3^n * 65536) for n below 9, 10.0 for n of 9
    function automatic logic [ACCEL_WIDTH-1:0] accel_q16(input logic [LEVEL_WIDTH-1:0] n);
        logic [ACCEL_WIDTH-1:0] f;
        begin
            case (n)
                4'd0:    f = 20'd65536;
                4'd1:    f = 20'd85197;
                4'd2:    f = 20'd110756;
                4'd3:    f = 20'd143983;
                4'd4:    f = 20'd187177;
                4'd5:    f = 20'd243331;
                4'd6:    f = 20'd316330;
                4'd7:    f = 20'd411229;
                4'd8:    f = 20'd534597;
                default: f = 20'd655360;
            endcase
            return f;
        end
    endfunction

    // Largest gap in us that still reaches speed level k (k from 1): floor(100000 / k)
    function automatic logic [16:0] gap_limit(input logic [LEVEL_WIDTH-1:0] k);
        logic [16:0] g;
        begin
            case (k)
                4'd1:    g = 17'd100000;
                4'd2:    g = 17'd50000;
                4'd3:    g = 17'd33333;
                4'd4:    g = 17'd25000;
                4'd5:    g = 17'd20000;
                4'd6:    g = 17'd16666;
                4'd7:    g = 17'd14285;
                4'd8:    g = 17'd12500;
                default: g = 17'd11111;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/qap_ctrl.sv @@
// Sequencing state machine for the quadrature accelerated position unit.
// Depends on qap_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module qap_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire qap_pkg::qap_status_t status,
    output qap_pkg::qap_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_GAP    = 6'b000100,
        S_RATE   = 6'b001000,
        S_MUL    = 6'b010000,
        S_CLAMP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load_sample = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = status.detent ? S_GAP : S_IDLE;
            end
            S_GAP:
            begin
                cmd.gap    = 1'b1;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/qap_datapath.sv @@
// Datapath: Gray decode, detent counting, gap measurement, acceleration and clamp.
// Depends on qap_pkg for widths, word types, tables and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module qap_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire qap_pkg::qap_cmd_t                      cmd,
    output qap_pkg::qap_status_t                        status,
    input  wire qap_pkg::in_word_t                      in_data,
    input  wire logic                                   cfg_write,
    input  wire logic [qap_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [qap_pkg::POSITION_WIDTH-1:0]     cfg_data,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output qap_pkg::out_word_t                          out_data
);

    // Configuration
    logic signed [qap_pkg::POSITION_WIDTH-1:0] min_reg;
    logic signed [qap_pkg::POSITION_WIDTH-1:0] max_reg;
    logic [qap_pkg::BASE_WIDTH-1:0]            base_reg;

    // Sample and decoder state
    logic [1:0]                          cur_pins_reg;
    logic [qap_pkg::TIME_WIDTH-1:0]      ts_reg;
    logic [1:0]                          prev_pins_reg;
    logic signed [qap_pkg::ACC_WIDTH-1:0] acc_reg;
    logic signed [qap_pkg::POSITION_WIDTH-1:0] count_reg;
    logic                                dir_reg;
    logic [qap_pkg::TIME_WIDTH-1:0]      last_time_reg;

    // Acceleration pipeline registers
    logic                                gap_ok_reg;
    logic [qap_pkg::TIME_WIDTH-1:0]      dt_reg;
    logic [qap_pkg::LEVEL_WIDTH-1:0]     level_reg;
    logic [qap_pkg::STEP_WIDTH-1:0]      step_reg;

    // Position carries one extra bit: the clamp can land one below the 32-bit range
    logic signed [qap_pkg::POSITION_WIDTH:0] pos_reg;

    // Output register
    logic               out_valid_reg;
    qap_pkg::out_word_t out_word_reg;

    // Combinational
    logic                                    step_up;
    logic                                    step_dn;
    logic signed [qap_pkg::ACC_WIDTH:0]      acc_sum;
    logic                                    detent;
    logic [qap_pkg::LEVEL_COUNT-1:0]         level_hits;
    logic [qap_pkg::PROD_WIDTH-1:0]          product;
    logic signed [qap_pkg::POSITION_WIDTH+2:0] pos_sum;
    logic signed [qap_pkg::POSITION_WIDTH+2:0] hi_ext;
    logic signed [qap_pkg::POSITION_WIDTH+2:0] lo_ext;
    logic signed [qap_pkg::POSITION_WIDTH+2:0] step_ext;
    logic signed [qap_pkg::POSITION_WIDTH+2:0] pos_clamped;
    logic signed [qap_pkg::POSITION_WIDTH:0]   pos_next;

    // Gray step decode: forward 0-1-3-2-0, backward the reverse
    always_comb
    begin
        step_up = 1'b0;
        step_dn = 1'b0;
        case ({prev_pins_reg, cur_pins_reg})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: step_up = 1'b1;
            4'b0100, 4'b1101, 4'b1011, 4'b0010: step_dn = 1'b1;
            default:
            begin
                step_up = 1'b0;
                step_dn = 1'b0;
            end
        endcase
    end

    // Accumulate Gray steps; four of one sign make a detent
    always_comb
    begin
        acc_sum = {acc_reg[qap_pkg::ACC_WIDTH-1], acc_reg};
        if (step_up)
            acc_sum = acc_sum + 4'sd1;
        else if (step_dn)
            acc_sum = acc_sum - 4'sd1;
        detent = (step_up || step_dn) && (acc_sum == 4'sd4 || acc_sum == -4'sd4);
    end

    // Speed level: count the levels whose gap limit the measured gap meets
    always_comb
    begin
        for (int k = 0; k < qap_pkg::LEVEL_COUNT; k++)
        begin
            level_hits[k] = dt_reg <= qap_pkg::TIME_WIDTH'(
                qap_pkg::gap_limit(qap_pkg::LEVEL_WIDTH'(k + 1)));
        end
    end

    assign product = qap_pkg::PROD_WIDTH'(base_reg) *
                     qap_pkg::PROD_WIDTH'(qap_pkg::accel_q16(level_reg));

    // Signed step added to the position, then clamped
    always_comb
    begin
        hi_ext   = (qap_pkg::POSITION_WIDTH+3)'(max_reg);
        lo_ext   = (qap_pkg::POSITION_WIDTH+3)'(min_reg);
        step_ext = (qap_pkg::POSITION_WIDTH+3)'(signed'({1'b0, step_reg}));
        pos_sum  = (qap_pkg::POSITION_WIDTH+3)'(pos_reg);
        if (dir_reg)
            pos_sum = pos_sum + step_ext;
        else
            pos_sum = pos_sum - step_ext;
        if (pos_sum >= hi_ext)
            pos_clamped = hi_ext - 1;
        else if (pos_sum < lo_ext)
            pos_clamped = lo_ext;
        else
            pos_clamped = pos_sum;
        pos_next = pos_clamped[qap_pkg::POSITION_WIDTH:0];
    end

    assign status.detent   = detent;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_word_reg;

    // Configuration registers and position; a write of the lower bound reloads the position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= qap_pkg::MIN_POSITION_RESET;
            max_reg  <= qap_pkg::MAX_POSITION_RESET;
            base_reg <= qap_pkg::BASE_STEP_RESET;
            pos_reg  <= (qap_pkg::POSITION_WIDTH+1)'(qap_pkg::MIN_POSITION_RESET);
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    qap_pkg::CFG_MIN_POSITION:
                    begin
                        min_reg <= cfg_data;
                        pos_reg <= (qap_pkg::POSITION_WIDTH+1)'(signed'(cfg_data));
                    end
                    qap_pkg::CFG_MAX_POSITION: max_reg  <= cfg_data;
                    qap_pkg::CFG_BASE_STEP:    base_reg <= cfg_data[qap_pkg::BASE_WIDTH-1:0];
                    default:                   ;
                endcase
            end
            else if (cmd.commit)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Latch the accepted sample
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            cur_pins_reg <= {in_data.pin_a, in_data.pin_b};
            ts_reg       <= in_data.sample_us;
        end
    end

    // Decoder state, detent count and last detent time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            dir_reg       <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (cmd.decode)
            begin
                prev_pins_reg <= cur_pins_reg;
                if (detent)
                begin
                    acc_reg <= '0;
                    dir_reg <= step_up;
                    if (step_up)
                        count_reg <= count_reg + qap_pkg::POSITION_WIDTH'(1);
                    else
                        count_reg <= count_reg - qap_pkg::POSITION_WIDTH'(1);
                end
                else if (step_up || step_dn)
                begin
                    acc_reg <= acc_sum[qap_pkg::ACC_WIDTH-1:0];
                end
            end
            if (cmd.gap)
                last_time_reg <= ts_reg;
        end
    end

    // Gap, speed level and step magnitude
    always_ff @(posedge clk)
    begin
        if (cmd.gap)
        begin
            gap_ok_reg <= (last_time_reg != '0) && (ts_reg > last_time_reg);
            dt_reg     <= ts_reg - last_time_reg;
        end
        if (cmd.rate)
            level_reg <= gap_ok_reg ?
                qap_pkg::LEVEL_WIDTH'($countones(level_hits)) : '0;
        if (cmd.mul)
            step_reg <= product[qap_pkg::PROD_WIDTH-1:qap_pkg::ACCEL_FRAC];
    end

    // Output register: load on commit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_word_reg.direction_up     <= dir_reg;
            out_word_reg.raw_count        <= count_reg;
            out_word_reg.mapped_position  <= pos_next[qap_pkg::POSITION_WIDTH-1:0];
            out_word_reg.position_changed <= pos_next != pos_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/quadrature_accelerated_position_unit.sv @@
// Top level of the quadrature accelerated position unit: controller plus datapath.
// Depends on qap_pkg, qap_ctrl and qap_datapath.
//
//   channel  signals                          word
//   in       in_valid / in_ready / in_data    qap_pkg::in_word_t (pins, timestamp)
//   out      out_valid / out_ready / out_data qap_pkg::out_word_t (one per detent)
//   cfg      cfg_valid / cfg_ready            cfg_index, cfg_data (always ready)
//
// A sample without a detent is accepted and decoded; a detent sample then goes
// through gap, speed level, multiply and clamp, the sequencer walking the single
// datapath one step a cycle while not stalled, and taking no new sample till idle.
// The clamp step waits while the output register still holds an untaken word.
// Reset is asynchronous, active low; the output register parts the two sides.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_accelerated_position_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire qap_pkg::in_word_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output qap_pkg::out_word_t                       out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [qap_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [qap_pkg::POSITION_WIDTH-1:0]  cfg_data
);

    qap_pkg::qap_cmd_t    cmd;
    qap_pkg::qap_status_t status;

    assign cfg_ready = 1'b1;

    qap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    qap_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ dv/tb_quadrature_accelerated_position_unit.sv @@
// Self-checking testbench for quadrature_accelerated_position_unit: drives pin samples and
// register writes, predicts every detent word and checks each one field by field.
// Depends on qap_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_quadrature_accelerated_position_unit;

    localparam logic [qap_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int unsigned PHASE_COUNT    = 9;
    localparam int unsigned PHASE_ITEMS    = 140;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        qap_pkg::in_word_t  sample;
        logic               typed;
        qap_pkg::out_word_t result;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    qap_pkg::in_word_t                   in_data;
    logic                                out_valid;
    logic                                out_ready;
    qap_pkg::out_word_t                  out_data;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [qap_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [qap_pkg::POSITION_WIDTH-1:0]  cfg_data;

    // Side information travelling with the offered sample word
    logic               row_typed;
    qap_pkg::out_word_t row_result;

    // Predictor state and its copy of the registers
    logic signed [qap_pkg::POSITION_WIDTH-1:0] cfg_min;
    logic signed [qap_pkg::POSITION_WIDTH-1:0] cfg_max;
    logic [qap_pkg::BASE_WIDTH-1:0]            cfg_base;
    logic [1:0]                                pins_q;
    int                                        accum;
    logic [qap_pkg::POSITION_WIDTH-1:0]        count_q;
    longint                                    pos_q;
    logic [qap_pkg::TIME_WIDTH-1:0]            last_us;

    qap_pkg::out_word_t expected_words [$];
    stim_row_t          stim_table [$];
    int unsigned        fail_count;
    int unsigned        idle_cycles;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    bit                 hold_request;

    // Sample generator state
    logic [qap_pkg::TIME_WIDTH-1:0] gen_now;
    logic [1:0]                     gen_pins;
    int unsigned                    gen_taken;

    quadrature_accelerated_position_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the decoder by one sample; return 1 and the word when a detent completes
    function automatic bit decode_sample(input qap_pkg::in_word_t w,
                                         output qap_pkg::out_word_t r);
        logic [1:0]      code;
        int              delta;
        bit              up;
        int              lvl;
        longint unsigned gap_us;
        longint unsigned quo;
        longint          fac;
        longint          stp;
        longint          lo;
        longint          hi;
        longint          p;
        longint          prior;
        begin
            r = '0;
            code = {w.pin_a, w.pin_b};
            case ({pins_q, code})
                4'b0001, 4'b0111, 4'b1110, 4'b1000: delta = 1;
                4'b0100, 4'b1101, 4'b1011, 4'b0010: delta = -1;
                default:                            delta = 0;
            endcase
            pins_q = code;
            if (delta == 0)
                return 0;
            accum = accum + delta;
            if (accum != 4 && accum != -4)
                return 0;
            up = accum > 0;
            accum = 0;
            count_q = up ? count_q + 32'd1 : count_q - 32'd1;

            // Speed level from the gap to the previous detent
            lvl = 0;
            if (last_us != '0 && w.sample_us > last_us)
            begin
                gap_us = 64'(w.sample_us) - 64'(last_us);
                quo = 64'd100000 / gap_us;
                lvl = (quo > 64'd9) ? 9 : int'(quo);
            end
            last_us = w.sample_us;

            case (lvl)
                0:       fac = 65536;
                1:       fac = 85197;
                2:       fac = 110756;
                3:       fac = 143983;
                4:       fac = 187177;
                5:       fac = 243331;
                6:       fac = 316330;
                7:       fac = 411229;
                default: fac = 534597;
            endcase
            if (lvl == 9)
                stp = longint'(cfg_base) * 10;
            else
                stp = (longint'(cfg_base) * fac) >> 16;

            // Clamp, upper bound first
            lo = cfg_min;
            hi = cfg_max;
            prior = pos_q;
            p = prior + (up ? stp : -stp);
            if (p >= hi)
                p = hi - 1;
            else if (p < lo)
                p = lo;
            pos_q = p;

            r.direction_up     = up;
            r.raw_count        = count_q;
            r.mapped_position  = 32'(p);
            r.position_changed = (p != prior);
            return 1;
        end
    endfunction

    // Observe all three channels at the rising edge
    always @(posedge clk)
    begin : monitor
        qap_pkg::out_word_t want;
        qap_pkg::out_word_t predicted;
        bit                 fired;
        bit                 moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.direction_up !== want.direction_up)
                    begin
                        $error("direction_up: expected %0d, actual %0d",
                               want.direction_up, out_data.direction_up);
                        fail_count++;
                    end
                    if (out_data.raw_count !== want.raw_count)
                    begin
                        $error("raw_count: expected %0d, actual %0d",
                               want.raw_count, out_data.raw_count);
                        fail_count++;
                    end
                    if (out_data.mapped_position !== want.mapped_position)
                    begin
                        $error("mapped_position: expected %0d, actual %0d",
                               want.mapped_position, out_data.mapped_position);
                        fail_count++;
                    end
                    if (out_data.position_changed !== want.position_changed)
                    begin
                        $error("position_changed: expected %0d, actual %0d",
                               want.position_changed, out_data.position_changed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                fired = decode_sample(in_data, predicted);
                if (row_typed)
                    expected_words = {expected_words, row_result};
                else if (fired)
                    expected_words = {expected_words, predicted};
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    qap_pkg::CFG_MIN_POSITION:
                    begin
                        cfg_min = cfg_data;
                        pos_q   = cfg_min;
                    end
                    qap_pkg::CFG_MAX_POSITION: cfg_max  = cfg_data;
                    qap_pkg::CFG_BASE_STEP:    cfg_base = cfg_data[qap_pkg::BASE_WIDTH-1:0];
                    default:                   ;
                endcase
            end
        end
        // Stop the run when nothing moves for too long
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, and a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one sample word; entered and left at a falling edge
    task automatic offer_sample(input qap_pkg::in_word_t w, input logic typed,
                                input qap_pkg::out_word_t result);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid   = 1'b1;
            in_data    = w;
            row_typed  = typed;
            row_result = result;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [qap_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [qap_pkg::POSITION_WIDTH-1:0] value);
        begin
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // Hold the sender until every expected word has come, then let the unit settle
    task automatic drain_pipeline();
        begin
            in_valid = 1'b0;
            while (expected_words.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic add_row(input int a, input int b,
                           input logic [qap_pkg::TIME_WIDTH-1:0] ts,
                           input int typed, input int up, input int count, input int pos,
                           input int changed);
        stim_row_t row;
        begin
            row.sample.pin_a               = 1'(a);
            row.sample.pin_b               = 1'(b);
            row.sample.sample_us           = ts;
            row.typed                      = 1'(typed);
            row.result.direction_up        = 1'(up);
            row.result.raw_count           = count;
            row.result.mapped_position     = pos;
            row.result.position_changed    = 1'(changed);
            stim_table = {stim_table, row};
        end
    endtask

    // Send one generated sample; pin changes count towards the phase quota
    task automatic emit_sample(input logic [1:0] code, input longint unsigned advance);
        qap_pkg::in_word_t w;
        begin
            gen_now     = gen_now + qap_pkg::TIME_WIDTH'(advance);
            w.pin_a     = code[1];
            w.pin_b     = code[0];
            w.sample_us = gen_now;
            if (code != gen_pins)
                gen_taken++;
            gen_pins = code;
            offer_sample(w, 1'b0, '0);
        end
    endtask

    task automatic run_random_phase(input int unsigned quota, input bit with_hold);
        int unsigned sel;
        int unsigned mode;
        int unsigned steps;
        int unsigned lo_gap;
        int unsigned hi_gap;
        bit          up;
        bit          hold_sent;
        logic [1:0]  nxt;
        begin
            gen_taken = 0;
            hold_sent = 1'b0;
            while (gen_taken < quota)
            begin
                if (with_hold && !hold_sent && gen_taken >= quota / 2)
                begin
                    hold_request = 1'b1;
                    hold_sent    = 1'b1;
                end
                sel = $urandom_range(99);
                if (sel < 75)
                begin
                    // Rotation burst; the step gap sets the speed level
                    up   = 1'($urandom_range(1));
                    mode = $urandom_range(5);
                    case (mode)
                        0:       begin lo_gap = 0;     hi_gap = 1000;  end
                        1:       begin lo_gap = 2500;  hi_gap = 25000; end
                        2:       begin lo_gap = 25001; hi_gap = 60000; end
                        3:       begin lo_gap = 0;     hi_gap = 0;     end
                        4:       begin lo_gap = 2200;  hi_gap = 3400;  end
                        default: begin lo_gap = 0;     hi_gap = 40000; end
                    endcase
                    steps = (sel < 10) ? $urandom_range(7, 1) : 4 * $urandom_range(5, 1);
                    for (int unsigned k = 0; k < steps; k++)
                    begin
                        if ($urandom_range(19) == 0)
                            emit_sample(gen_pins, $urandom_range(hi_gap));
                        case (gen_pins)
                            2'b00:   nxt = up ? 2'b01 : 2'b10;
                            2'b01:   nxt = up ? 2'b11 : 2'b00;
                            2'b11:   nxt = up ? 2'b10 : 2'b01;
                            default: nxt = up ? 2'b00 : 2'b11;
                        endcase
                        emit_sample(nxt, $urandom_range(hi_gap, lo_gap));
                        // Broken burst: turn back halfway
                        if (sel < 10 && k == steps / 2)
                            up = !up;
                    end
                end
                else if (sel < 95)
                begin
                    emit_sample(2'($urandom_range(3)), $urandom_range(5000));
                end
                else
                begin
                    // Jump the clock anywhere, now and then to zero
                    if ($urandom_range(3) == 0)
                        gen_now = '0;
                    else
                        gen_now = {16'($urandom), 32'($urandom)};
                    emit_sample(2'($urandom_range(3)), 0);
                end
            end
        end
    endtask

    initial
    begin
        logic signed [qap_pkg::POSITION_WIDTH-1:0] lo;
        logic signed [qap_pkg::POSITION_WIDTH-1:0] hi;
        logic [qap_pkg::BASE_WIDTH-1:0]            bs;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = qap_pkg::CFG_MIN_POSITION;
        cfg_data     = '0;
        row_typed    = 1'b0;
        row_result   = '0;
        fail_count   = 0;
        idle_cycles  = 0;
        hold_request = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 48;
        cfg_min      = qap_pkg::MIN_POSITION_RESET;
        cfg_max      = qap_pkg::MAX_POSITION_RESET;
        cfg_base     = qap_pkg::BASE_STEP_RESET;
        pins_q       = 2'b00;
        accum        = 0;
        count_q      = '0;
        pos_q        = qap_pkg::MIN_POSITION_RESET;
        last_us      = '0;
        gen_now      = '0;
        gen_pins     = 2'b00;
        gen_taken    = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first detent after reset, fast reverse clamped at min, no-change
        // and jump samples, detent at time zero, timestamps at the top and going back
        add_row(0, 1, 48'd1000,  0, 0, 0, 0, 0);
        add_row(1, 1, 48'd2000,  0, 0, 0, 0, 0);
        add_row(1, 0, 48'd3000,  0, 0, 0, 0, 0);
        add_row(0, 0, 48'd4000,  1, 1, 1, 1, 1);
        add_row(0, 0, 48'd5000,  0, 0, 0, 0, 0);
        add_row(1, 1, 48'd6000,  0, 0, 0, 0, 0);
        add_row(0, 1, 48'd8000,  0, 0, 0, 0, 0);
        add_row(0, 0, 48'd10000, 0, 0, 0, 0, 0);
        add_row(1, 0, 48'd12000, 0, 0, 0, 0, 0);
        add_row(1, 1, 48'd14000, 1, 0, 0, 0, 1);
        add_row(1, 0, 48'd20,    0, 0, 0, 0, 0);
        add_row(0, 0, 48'd10,    0, 0, 0, 0, 0);
        add_row(0, 1, 48'd5,     0, 0, 0, 0, 0);
        add_row(1, 1, 48'd0,     1, 1, 1, 1, 1);
        add_row(1, 0, 48'd100,   0, 0, 0, 0, 0);
        add_row(0, 0, 48'd200,   0, 0, 0, 0, 0);
        add_row(0, 1, 48'd300,   0, 0, 0, 0, 0);
        add_row(1, 1, 48'hFFFF_FFFF_FFFF, 1, 1, 2, 2, 1);
        add_row(1, 0, 48'd400,   0, 0, 0, 0, 0);
        add_row(0, 0, 48'd500,   0, 0, 0, 0, 0);
        add_row(0, 1, 48'd600,   0, 0, 0, 0, 0);
        add_row(1, 1, 48'hFFFF_FFFF_FFFE, 1, 1, 3, 3, 1);
        add_row(0, 1, 48'd700,   0, 0, 0, 0, 0);
        add_row(1, 0, 48'd800,   0, 0, 0, 0, 0);
        add_row(0, 0, 48'd900,   0, 0, 0, 0, 0);

        foreach (stim_table[i])
            offer_sample(stim_table[i].sample, stim_table[i].typed, stim_table[i].result);
        gen_pins = 2'b00;
        gen_now  = 48'd1000;

        // Random phases, each under its own register setting
        for (int unsigned ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain_pipeline();
            case (ph)
                0:       begin lo = 0;             hi = 100;           bs = 1;     end
                1:       begin lo = -50;           hi = 50;            bs = 7;     end
                2:       begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; bs = 16'hFFFF; end
                3:       begin lo = 2147483000;    hi = 32'h7FFF_FFFF; bs = 16'hFFFF; end
                4:       begin lo = 32'h8000_0000; hi = -2147482000;   bs = 16'hFFFF; end
                5:       begin lo = 10;            hi = 5;             bs = 3;     end
                6:       begin lo = 0;             hi = 32'h8000_0000; bs = 0;     end
                7:       begin lo = -1000;         hi = 1000;          bs = 100;   end
                default: begin lo = $urandom;      hi = $urandom;      bs = 16'($urandom); end
            endcase
            write_register(qap_pkg::CFG_BASE_STEP, {16'($urandom), bs});
            write_register(qap_pkg::CFG_MAX_POSITION, hi);
            write_register(qap_pkg::CFG_MIN_POSITION, lo);
            if (ph == 0)
                write_register(CFG_UNUSED_INDEX, $urandom);
            if (ph < 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 48;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(PHASE_ITEMS, ph == 1 || ph == 7);
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
